/* design/q2e_pkg.sv */
package q2e_pkg;

    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int MAX_STAGES          = 24;

    // internal angle: 2^-16 degree
    localparam int INT_ANGLE_BITS = 16;
    localparam int ANG_W          = 26;
    localparam int VEC_W          = 40;
    localparam int ARG_W          = 36;
    localparam int SP_W           = 32;
    localparam int SQ_STEPS       = 31;

    localparam logic signed [ARG_W-1:0] ONE_Q30 = ARG_W'(64'sd1073741824);
    localparam logic signed [ARG_W-1:0] LOCK_TH = ARG_W'(64'sd1073731086);
    localparam logic signed [ANG_W-1:0] DEG90   = ANG_W'(90 <<< INT_ANGLE_BITS);
    localparam logic signed [ANG_W-1:0] DEG180  = ANG_W'(180 <<< INT_ANGLE_BITS);

    typedef struct packed {
        logic                    lock;
        logic                    sp_neg;
        logic signed [SP_W-1:0]  sp;
        logic signed [ARG_W-1:0] yaw_y;
        logic signed [ARG_W-1:0] yaw_x;
        logic signed [ARG_W-1:0] roll_y;
        logic signed [ARG_W-1:0] roll_x;
    } t_ctx;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
    } t_cvec;

    function automatic logic signed [ANG_W-1:0] atan_lut(input int unsigned i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = ANG_W'(2949120);
            1:       v = ANG_W'(1740967);
            2:       v = ANG_W'(919879);
            3:       v = ANG_W'(466945);
            4:       v = ANG_W'(234379);
            5:       v = ANG_W'(117304);
            6:       v = ANG_W'(58666);
            7:       v = ANG_W'(29335);
            8:       v = ANG_W'(14668);
            9:       v = ANG_W'(7334);
            10:      v = ANG_W'(3667);
            11:      v = ANG_W'(1833);
            12:      v = ANG_W'(917);
            13:      v = ANG_W'(458);
            14:      v = ANG_W'(229);
            15:      v = ANG_W'(115);
            16:      v = ANG_W'(57);
            17:      v = ANG_W'(29);
            18:      v = ANG_W'(14);
            19:      v = ANG_W'(7);
            20:      v = ANG_W'(4);
            21:      v = ANG_W'(2);
            22:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // fold the left half plane onto the right one
    function automatic t_cvec pre_rotate(input logic signed [ARG_W-1:0] y,
                                         input logic signed [ARG_W-1:0] x);
        t_cvec v;
        v.x = VEC_W'(x);
        v.y = VEC_W'(y);
        v.z = '0;
        if (x < 0) begin
            v.z = (y >= 0) ? DEG180 : -DEG180;
            v.x = -VEC_W'(x);
            v.y = -VEC_W'(y);
        end
        return v;
    endfunction

    function automatic t_cvec cordic_step(input t_cvec a, input int unsigned i);
        t_cvec                   v;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        xs = a.x >>> i;
        ys = a.y >>> i;
        if (a.y > 0) begin
            v.x = a.x + ys;
            v.y = a.y - xs;
            v.z = a.z + atan_lut(i);
        end else begin
            v.x = a.x - ys;
            v.y = a.y + xs;
            v.z = a.z - atan_lut(i);
        end
        return v;
    endfunction

endpackage

/* design/quaternion_to_euler_angles.sv */
// Quaternion to Euler angles (pitch, yaw, roll) with gimbal-lock handling.
// Input: drive start high with i_func and the four Q1.15 components; the item
// transfers on that edge. busy stays low, so one quaternion can enter every
// cycle and the throughput is one item per clock.
// Output: o_valid pulses for one cycle with pitch, yaw, roll (2^-ANGLE_FRAC_BITS
// degree units) and the gimbal-lock flag. The receiver cannot stall; results
// leave in input order.
// The pipeline runs conjugate, products, sums and pitch-sine square, then the
// one-bit-per-stage square root for the pitch cosine, the quadrant fold, the
// CORDIC stages (three CORDICs side by side), and rounding and saturation.
// A synchronous low i_rst_n clears every valid bit; items in flight are
// dropped and no strobe follows until new items arrive.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES   = q2e_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = q2e_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    output logic signed [14:0] o_pitch_deg,
    output logic signed [15:0] o_yaw_deg,
    output logic signed [15:0] o_roll_deg,
    output logic               o_gimbal_lock
);
    import q2e_pkg::*;

    localparam int SH_RAW    = INT_ANGLE_BITS - ANGLE_FRAC_BITS;
    localparam int OUT_SHIFT = (SH_RAW < 1) ? 1 : ((SH_RAW > 15) ? 15 : SH_RAW);
    localparam int RND_W     = ANG_W + 1;
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (OUT_SHIFT - 1);

    assign busy = 1'b0;

    // conjugate when i_func is set
    logic                    r_s1_vld;
    logic signed [16:0]      r_w, r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= 17'(i_quat_w);
        r_x <= i_func ? -17'(i_quat_x) : 17'(i_quat_x);
        r_y <= i_func ? -17'(i_quat_y) : 17'(i_quat_y);
        r_z <= i_func ? -17'(i_quat_z) : 17'(i_quat_z);
    end

    // products, exact Q2.30
    logic                    r_s2_vld;
    logic signed [33:0]      r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= r_x * r_x;
        r_yy <= r_y * r_y;
        r_zz <= r_z * r_z;
        r_xy <= r_x * r_y;
        r_xz <= r_x * r_z;
        r_yz <= r_y * r_z;
        r_wx <= r_w * r_x;
        r_wy <= r_w * r_y;
        r_wz <= r_w * r_z;
    end

    // pitch sine, clamp, lock test and atan2 arguments
    logic                    r_s3_vld;
    t_ctx                    r_s3_ctx;
    t_ctx                    n_s3_ctx;
    logic signed [ARG_W-1:0] sp_raw;
    logic signed [ARG_W-1:0] sp_cl;
    logic signed [ARG_W-1:0] sp_mag;

    always_comb begin
        sp_raw = -(ARG_W'(r_xz) - ARG_W'(r_wy)) <<< 1;
        sp_cl  = sp_raw;
        if (sp_raw > ONE_Q30) begin
            sp_cl = ONE_Q30;
        end
        if (sp_raw < -ONE_Q30) begin
            sp_cl = -ONE_Q30;
        end
        sp_mag          = (sp_cl < 0) ? -sp_cl : sp_cl;
        n_s3_ctx.lock   = sp_mag > LOCK_TH;
        n_s3_ctx.sp_neg = sp_cl < 0;
        n_s3_ctx.sp     = SP_W'(sp_cl);
        if (n_s3_ctx.lock) begin
            n_s3_ctx.yaw_y = -(ARG_W'(r_xy) - ARG_W'(r_wz)) <<< 1;
            n_s3_ctx.yaw_x = ONE_Q30 - ((ARG_W'(r_xx) + ARG_W'(r_zz)) <<< 1);
        end else begin
            n_s3_ctx.yaw_y = (ARG_W'(r_xy) + ARG_W'(r_wz)) <<< 1;
            n_s3_ctx.yaw_x = ONE_Q30 - ((ARG_W'(r_yy) + ARG_W'(r_zz)) <<< 1);
        end
        n_s3_ctx.roll_y = (ARG_W'(r_yz) + ARG_W'(r_wx)) <<< 1;
        n_s3_ctx.roll_x = ONE_Q30 - ((ARG_W'(r_xx) + ARG_W'(r_yy)) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_ctx <= n_s3_ctx;
    end

    // sine squared
    logic                    r_s4_vld;
    t_ctx                    r_s4_ctx;
    logic [60:0]             r_s4_sq;
    logic signed [63:0]      sq_full;

    assign sq_full = r_s3_ctx.sp * r_s3_ctx.sp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_ctx <= r_s3_ctx;
        r_s4_sq  <= sq_full[60:0];
    end

    // floor square root of 2^60 - sp^2, one result bit per stage
    logic                    r_sq_vld  [0:SQ_STEPS];
    t_ctx                    r_sq_ctx  [0:SQ_STEPS];
    logic [61:0]             r_sq_v    [0:SQ_STEPS];
    logic [34:0]             r_sq_rem  [0:SQ_STEPS];
    logic [30:0]             r_sq_root [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else begin
            r_sq_vld[0] <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_ctx[0]  <= r_s4_ctx;
        r_sq_v[0]    <= (62'(1) << 60) - 62'(r_s4_sq);
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [34:0] rem_sh;
        logic [34:0] trial;

        assign rem_sh = {r_sq_rem[k][32:0], r_sq_v[k][61-2*k -: 2]};
        assign trial  = {2'b00, r_sq_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else begin
                r_sq_vld[k+1] <= r_sq_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_ctx[k+1] <= r_sq_ctx[k];
            r_sq_v[k+1]   <= r_sq_v[k];
            if (rem_sh >= trial) begin
                r_sq_rem[k+1]  <= rem_sh - trial;
                r_sq_root[k+1] <= {r_sq_root[k][29:0], 1'b1};
            end else begin
                r_sq_rem[k+1]  <= rem_sh;
                r_sq_root[k+1] <= {r_sq_root[k][29:0], 1'b0};
            end
        end
    end

    // three vectoring CORDICs in lockstep
    logic                    r_c_vld  [0:CORDIC_STAGES];
    t_ctx                    r_c_ctx  [0:CORDIC_STAGES];
    t_cvec                   r_c_p    [0:CORDIC_STAGES];
    t_cvec                   r_c_yaw  [0:CORDIC_STAGES];
    t_cvec                   r_c_roll [0:CORDIC_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld[0] <= 1'b0;
        end else begin
            r_c_vld[0] <= r_sq_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_ctx[0]  <= r_sq_ctx[SQ_STEPS];
        r_c_p[0]    <= pre_rotate(ARG_W'(r_sq_ctx[SQ_STEPS].sp),
                                  ARG_W'({1'b0, r_sq_root[SQ_STEPS]}));
        r_c_yaw[0]  <= pre_rotate(r_sq_ctx[SQ_STEPS].yaw_y, r_sq_ctx[SQ_STEPS].yaw_x);
        r_c_roll[0] <= pre_rotate(r_sq_ctx[SQ_STEPS].roll_y, r_sq_ctx[SQ_STEPS].roll_x);
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[i+1] <= 1'b0;
            end else begin
                r_c_vld[i+1] <= r_c_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_c_ctx[i+1]  <= r_c_ctx[i];
            r_c_p[i+1]    <= cordic_step(r_c_p[i], i);
            r_c_yaw[i+1]  <= cordic_step(r_c_yaw[i], i);
            r_c_roll[i+1] <= cordic_step(r_c_roll[i], i);
        end
    end

    // gimbal-lock override, round half up, saturate
    t_ctx                    fin_ctx;
    logic signed [ANG_W-1:0] ang_p, ang_y, ang_r;
    logic signed [RND_W-1:0] rnd_p, rnd_y, rnd_r;
    logic signed [14:0]      n_pitch;
    logic signed [15:0]      n_yaw, n_roll;
    logic                    r_o_vld;
    logic signed [14:0]      r_pitch;
    logic signed [15:0]      r_yaw, r_roll;
    logic                    r_lock;

    always_comb begin
        fin_ctx = r_c_ctx[CORDIC_STAGES];
        ang_y   = r_c_yaw[CORDIC_STAGES].z;
        if (fin_ctx.lock) begin
            ang_p = fin_ctx.sp_neg ? -DEG90 : DEG90;
            ang_r = '0;
        end else begin
            ang_p = r_c_p[CORDIC_STAGES].z;
            ang_r = r_c_roll[CORDIC_STAGES].z;
        end
        rnd_p = (RND_W'(ang_p) + RND_HALF) >>> OUT_SHIFT;
        rnd_y = (RND_W'(ang_y) + RND_HALF) >>> OUT_SHIFT;
        rnd_r = (RND_W'(ang_r) + RND_HALF) >>> OUT_SHIFT;

        if (rnd_p < RND_W'(-16384)) begin
            n_pitch = 15'(-16384);
        end else if (rnd_p > RND_W'(16383)) begin
            n_pitch = 15'(16383);
        end else begin
            n_pitch = rnd_p[14:0];
        end
        if (rnd_y < RND_W'(-32768)) begin
            n_yaw = 16'(-32768);
        end else if (rnd_y > RND_W'(32767)) begin
            n_yaw = 16'(32767);
        end else begin
            n_yaw = rnd_y[15:0];
        end
        if (rnd_r < RND_W'(-32768)) begin
            n_roll = 16'(-32768);
        end else if (rnd_r > RND_W'(32767)) begin
            n_roll = 16'(32767);
        end else begin
            n_roll = rnd_r[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= r_c_vld[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pitch <= n_pitch;
        r_yaw   <= n_yaw;
        r_roll  <= n_roll;
        r_lock  <= fin_ctx.lock;
    end

    assign o_valid       = r_o_vld;
    assign o_pitch_deg   = r_pitch;
    assign o_yaw_deg     = r_yaw;
    assign o_roll_deg    = r_roll;
    assign o_gimbal_lock = r_lock;

endmodule
